// ----- rtl/stok_pkg.sv -----
// ----------------------------------------------------------------------------
// stok_pkg: shared types and constants of the source tokenizer
// Word formats of the byte and token channels, token kinds, character codes
// and the sizing of the token queue.
// ----------------------------------------------------------------------------
package stok_pkg;

   // field widths
   localparam int POS_BITS   = 32;
   localparam int LEN_BITS   = 16;
   localparam int DEPTH_BITS = 8;

   // one byte can give at most this many tokens
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // token kinds
   localparam logic [4:0] K_EOF       = 5'd0;
   localparam logic [4:0] K_IDENT     = 5'd1;
   localparam logic [4:0] K_NUMBER    = 5'd2;
   localparam logic [4:0] K_STRING    = 5'd3;
   localparam logic [4:0] K_LPAREN    = 5'd4;
   localparam logic [4:0] K_RPAREN    = 5'd5;
   localparam logic [4:0] K_LBRACE    = 5'd6;
   localparam logic [4:0] K_RBRACE    = 5'd7;
   localparam logic [4:0] K_PLUS      = 5'd8;
   localparam logic [4:0] K_MINUS     = 5'd9;
   localparam logic [4:0] K_STAR      = 5'd10;
   localparam logic [4:0] K_COMMA     = 5'd11;
   localparam logic [4:0] K_PERIOD    = 5'd12;
   localparam logic [4:0] K_SEMI      = 5'd13;
   localparam logic [4:0] K_BANG      = 5'd14;
   localparam logic [4:0] K_EQUAL     = 5'd16;
   localparam logic [4:0] K_LESS      = 5'd18;
   localparam logic [4:0] K_GREATER   = 5'd20;
   localparam logic [4:0] K_SLASH     = 5'd22;
   localparam logic [4:0] K_UNKNOWN   = 5'd23;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_STRING  = 2'd1;
   localparam logic [1:0] ERR_COMMENT = 2'd2;

   // characters with a role of their own
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [4:0]          token_kind;
      logic [POS_BITS-1:0] token_start;
      logic [LEN_BITS-1:0] token_length;
      logic [1:0]          error_code;
      logic                last;
   } rsp_word_type;

   // tokens caused by one byte, in emission order (valid bits not compacted)
   typedef struct packed {
      logic [MAX_RESULTS-1:0]               valid;
      rsp_word_type [MAX_RESULTS-1:0]       word;
   } stok_bundle_type;

endpackage

// ----- rtl/stok_scan.sv -----
// ----------------------------------------------------------------------------
// stok_scan: scanner state and per-byte step
// Holds the scan state and works out, for each accepted word, the next
// state and the tokens it causes (flushed token, split-off period, new token or eof).
// ----------------------------------------------------------------------------
module stok_scan import stok_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  req_word_type    in_word,
   output stok_bundle_type bundle
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUM_INT,
      MODE_NUM_DOT,
      MODE_NUM_FRAC,
      MODE_STRING,
      MODE_OPER,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BLOCK_SLASH,
      MODE_BLOCK_STAR
   } mode_type;

   localparam logic [LEN_BITS-1:0]   LEN_MAX   = {LEN_BITS{1'b1}};
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0]   LEN_ONE   = LEN_BITS'(1);
   localparam logic [LEN_BITS-1:0]   LEN_TWO   = LEN_BITS'(2);

   mode_type              mode_ff, mode_in;
   logic [7:0]            pend_ff, pend_in;
   logic [POS_BITS-1:0]   origin_ff, origin_in;
   logic [LEN_BITS-1:0]   count_ff, count_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;

   function automatic rsp_word_type make_tok(logic [4:0] kind, logic [POS_BITS-1:0] start,
                                             logic [LEN_BITS-1:0] len, logic [1:0] err);
      rsp_word_type w;
      w.token_kind   = kind;
      w.token_start  = start;
      w.token_length = len;
      w.error_code   = err;
      w.last         = 1'b0;
      return w;
   endfunction

   function automatic logic [LEN_BITS-1:0] sat_add(logic [LEN_BITS-1:0] cnt, logic [1:0] inc);
      logic [LEN_BITS:0] sum;
      sum = {1'b0, cnt} + {{(LEN_BITS-1){1'b0}}, inc};
      return (sum > {1'b0, LEN_MAX}) ? LEN_MAX : sum[LEN_BITS-1:0];
   endfunction

   // one-byte kind of a pending operator
   function automatic logic [4:0] op_single(logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         "!":      k = K_BANG;
         "=":      k = K_EQUAL;
         "<":      k = K_LESS;
         ">":      k = K_GREATER;
         default:  k = K_SLASH;
      endcase
      return k;
   endfunction

   logic       is_space, is_digit, is_head, is_word;
   mode_type   b_mode;
   logic       b_emit, b_pend;
   logic [4:0] b_kind;

   // character classes
   assign is_space = (in_word.ch == " ") || (in_word.ch == 8'h09) || (in_word.ch == 8'h0C) ||
                     (in_word.ch == 8'h0B) || (in_word.ch == CH_CR) || (in_word.ch == CH_LF);
   assign is_digit = (in_word.ch >= "0") && (in_word.ch <= "9");
   assign is_head  = (in_word.ch == CH_UNDER) || ((in_word.ch >= "A") && (in_word.ch <= "Z")) ||
                     ((in_word.ch >= "a") && (in_word.ch <= "z"));
   assign is_word  = is_head || is_digit;

   // what an idle scanner does with this byte
   always_comb begin
      b_mode = MODE_IDLE;
      b_emit = 1'b0;
      b_pend = 1'b0;
      b_kind = K_UNKNOWN;
      priority if (is_space) begin
         b_mode = MODE_IDLE;
      end else if (is_head) begin
         b_mode = MODE_IDENT;
      end else if (is_digit) begin
         b_mode = MODE_NUM_INT;
      end else if (in_word.ch == CH_QUOTE) begin
         b_mode = MODE_STRING;
      end else begin
         unique case (in_word.ch)
            "(":     begin b_emit = 1'b1; b_kind = K_LPAREN;  end
            ")":     begin b_emit = 1'b1; b_kind = K_RPAREN;  end
            "{":     begin b_emit = 1'b1; b_kind = K_LBRACE;  end
            "}":     begin b_emit = 1'b1; b_kind = K_RBRACE;  end
            "+":     begin b_emit = 1'b1; b_kind = K_PLUS;    end
            "-":     begin b_emit = 1'b1; b_kind = K_MINUS;   end
            "*":     begin b_emit = 1'b1; b_kind = K_STAR;    end
            ",":     begin b_emit = 1'b1; b_kind = K_COMMA;   end
            ".":     begin b_emit = 1'b1; b_kind = K_PERIOD;  end
            ";":     begin b_emit = 1'b1; b_kind = K_SEMI;    end
            "!", "=", "<", ">", "/": begin
               b_mode = MODE_OPER;
               b_pend = 1'b1;
            end
            default: begin b_emit = 1'b1; b_kind = K_UNKNOWN; end
         endcase
      end
   end

   // next state and tokens for one word
   always_comb begin
      logic do_begin;
      logic [LEN_BITS-1:0]   cnt_inc;
      logic [DEPTH_BITS-1:0] depth_dec;
      logic [1:0]            eof_err;

      do_begin  = 1'b0;
      cnt_inc   = sat_add(count_ff, 2'd1);
      depth_dec = (depth_ff != '0) ? depth_ff - DEPTH_BITS'(1) : depth_ff;
      eof_err   = ERR_NONE;

      mode_in   = mode_ff;
      pend_in   = pend_ff;
      origin_in = origin_ff;
      count_in  = count_ff;
      depth_in  = depth_ff;
      pos_in    = pos_ff;
      bundle    = '0;

      if (take && in_word.end_of_text) begin
         // flush pending token, then eof; state back to reset
         unique case (mode_ff)
            MODE_IDENT: begin
               bundle.valid[0] = 1'b1;
               bundle.word[0]  = make_tok(K_IDENT, origin_ff, count_ff, ERR_NONE);
            end
            MODE_NUM_INT, MODE_NUM_FRAC: begin
               bundle.valid[0] = 1'b1;
               bundle.word[0]  = make_tok(K_NUMBER, origin_ff, count_ff, ERR_NONE);
            end
            MODE_NUM_DOT: begin
               bundle.valid[0] = 1'b1;
               bundle.word[0]  = make_tok(K_NUMBER, origin_ff, count_ff, ERR_NONE);
               bundle.valid[1] = 1'b1;
               bundle.word[1]  = make_tok(K_PERIOD, pos_ff - POS_BITS'(1), LEN_ONE, ERR_NONE);
            end
            MODE_STRING: begin
               bundle.valid[0] = 1'b1;
               bundle.word[0]  = make_tok(K_STRING, origin_ff, count_ff, ERR_STRING);
            end
            MODE_OPER: begin
               bundle.valid[0] = 1'b1;
               bundle.word[0]  = make_tok(op_single(pend_ff), origin_ff, LEN_ONE, ERR_NONE);
            end
            MODE_BLOCK, MODE_BLOCK_SLASH, MODE_BLOCK_STAR: eof_err = ERR_COMMENT;
            default: ;
         endcase
         bundle.valid[2] = 1'b1;
         bundle.word[2]  = make_tok(K_EOF, pos_ff, '0, eof_err);
         mode_in   = MODE_IDLE;
         pend_in   = '0;
         origin_in = '0;
         count_in  = '0;
         depth_in  = '0;
         pos_in    = '0;
      end else if (take) begin
         pos_in = pos_ff + POS_BITS'(1);
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_word) begin
                  count_in = cnt_inc;
               end else begin
                  bundle.valid[0] = 1'b1;
                  bundle.word[0]  = make_tok(K_IDENT, origin_ff, count_ff, ERR_NONE);
                  do_begin = 1'b1;
               end
            end
            MODE_NUM_INT: begin
               if (is_digit) begin
                  count_in = cnt_inc;
               end else if (in_word.ch == CH_DOT) begin
                  mode_in = MODE_NUM_DOT;
               end else begin
                  bundle.valid[0] = 1'b1;
                  bundle.word[0]  = make_tok(K_NUMBER, origin_ff, count_ff, ERR_NONE);
                  do_begin = 1'b1;
               end
            end
            MODE_NUM_DOT: begin
               if (is_digit) begin
                  count_in = sat_add(count_ff, 2'd2);
                  mode_in  = MODE_NUM_FRAC;
               end else begin
                  bundle.valid[0] = 1'b1;
                  bundle.word[0]  = make_tok(K_NUMBER, origin_ff, count_ff, ERR_NONE);
                  bundle.valid[1] = 1'b1;
                  bundle.word[1]  = make_tok(K_PERIOD, pos_ff - POS_BITS'(1), LEN_ONE, ERR_NONE);
                  do_begin = 1'b1;
               end
            end
            MODE_NUM_FRAC: begin
               if (is_digit) begin
                  count_in = cnt_inc;
               end else begin
                  bundle.valid[0] = 1'b1;
                  bundle.word[0]  = make_tok(K_NUMBER, origin_ff, count_ff, ERR_NONE);
                  do_begin = 1'b1;
               end
            end
            MODE_STRING: begin
               count_in = cnt_inc;
               if (in_word.ch == CH_QUOTE) begin
                  bundle.valid[0] = 1'b1;
                  bundle.word[0]  = make_tok(K_STRING, origin_ff, cnt_inc, ERR_NONE);
                  mode_in = MODE_IDLE;
               end else if ((in_word.ch == CH_LF) || (in_word.ch == CH_CR)) begin
                  bundle.valid[0] = 1'b1;
                  bundle.word[0]  = make_tok(K_STRING, origin_ff, cnt_inc, ERR_STRING);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_OPER: begin
               if (pend_ff == CH_SLASH) begin
                  if (in_word.ch == CH_SLASH) begin
                     mode_in = MODE_LINE;
                  end else if (in_word.ch == CH_STAR) begin
                     depth_in = DEPTH_BITS'(1);
                     mode_in  = MODE_BLOCK;
                  end else begin
                     bundle.valid[0] = 1'b1;
                     bundle.word[0]  = make_tok(K_SLASH, origin_ff, LEN_ONE, ERR_NONE);
                     do_begin = 1'b1;
                  end
               end else if (in_word.ch == CH_EQUAL) begin
                  // two-byte form is the next kind code
                  bundle.valid[0] = 1'b1;
                  bundle.word[0]  = make_tok(op_single(pend_ff) + 5'd1, origin_ff, LEN_TWO,
                                             ERR_NONE);
                  mode_in = MODE_IDLE;
               end else begin
                  bundle.valid[0] = 1'b1;
                  bundle.word[0]  = make_tok(op_single(pend_ff), origin_ff, LEN_ONE, ERR_NONE);
                  do_begin = 1'b1;
               end
            end
            MODE_LINE: begin
               if (in_word.ch == CH_LF) mode_in = MODE_IDLE;
            end
            MODE_BLOCK_SLASH, MODE_BLOCK_STAR, MODE_BLOCK: begin
               if ((mode_ff == MODE_BLOCK_SLASH) && (in_word.ch == CH_STAR)) begin
                  if (depth_ff != DEPTH_MAX) depth_in = depth_ff + DEPTH_BITS'(1);
                  mode_in = MODE_BLOCK;
               end else if ((mode_ff == MODE_BLOCK_STAR) && (in_word.ch == CH_SLASH)) begin
                  depth_in = depth_dec;
                  mode_in  = (depth_dec == '0) ? MODE_IDLE : MODE_BLOCK;
               end else if (in_word.ch == CH_SLASH) begin
                  mode_in = MODE_BLOCK_SLASH;
               end else if (in_word.ch == CH_STAR) begin
                  mode_in = MODE_BLOCK_STAR;
               end else begin
                  mode_in = MODE_BLOCK;
               end
            end
            default: do_begin = 1'b1;
         endcase

         // start of a new token at this byte
         if (do_begin) begin
            mode_in   = b_mode;
            origin_in = pos_ff;
            count_in  = LEN_ONE;
            if (b_pend) pend_in = in_word.ch;
            if (b_emit) begin
               bundle.valid[2] = 1'b1;
               bundle.word[2]  = make_tok(b_kind, pos_ff, LEN_ONE, ERR_NONE);
            end
         end
      end

      // mark the final token of this word
      if (bundle.valid[2]) begin
         bundle.word[2].last = 1'b1;
      end else if (bundle.valid[1]) begin
         bundle.word[1].last = 1'b1;
      end else if (bundle.valid[0]) begin
         bundle.word[0].last = 1'b1;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= '0;
         origin_ff <= '0;
         count_ff  <= '0;
         depth_ff  <= '0;
         pos_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         origin_ff <= origin_in;
         count_ff  <= count_in;
         depth_ff  <= depth_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

// ----- rtl/stok_queue.sv -----
// ----------------------------------------------------------------------------
// stok_queue: token result queue
// Small register queue that takes up to three tokens per cycle in order and
// hands out one token per cycle on the result channel while out_ready is high.
// ----------------------------------------------------------------------------
module stok_queue import stok_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  stok_bundle_type bundle,
   output logic            room,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_word_type    out_word
);

   rsp_word_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [QPTR_BITS-1:0]  offs [MAX_RESULTS];
   logic [QCNT_BITS-1:0]  npush;
   logic                  pop;

   // place of each token relative to the write pointer
   always_comb begin
      logic [QCNT_BITS-1:0] acc;
      acc = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         offs[i] = acc[QPTR_BITS-1:0];
         acc     = acc + QCNT_BITS'(bundle.valid[i]);
      end
      npush = acc;
   end

   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_word  = slot_ff[rd_ptr_ff];
   assign room      = (cnt_ff <= QCNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));

   assign wr_ptr_in = wr_ptr_ff + npush[QPTR_BITS-1:0];
   assign rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
   assign cnt_in    = cnt_ff + npush - QCNT_BITS'(pop);

   // token storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (bundle.valid[i]) slot_ff[wr_ptr_ff + offs[i]] <= bundle.word[i];
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- rtl/source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_tokenizer: streaming lexical scanner
// Top level: byte channel into the scanner, tokens out through a queue.
// ----------------------------------------------------------------------------
// One source byte (or an end-of-text mark) is taken per word on req_ and is
// scanned in the cycle it is accepted; it yields zero to three tokens, which
// enter a four-entry token queue and leave on rsp_ one per cycle. req_ready
// is high while the queue holds at most one token, so with rsp_ready high and
// at most one token per byte the block takes one byte every clock cycle. A
// byte that yields two or three tokens (a token cut short by a one-byte
// token, a number cut short before a period, end of text) holds the byte
// channel while the single result port drains the queue. End of text emits
// any pending token, then an eof token, and returns the scanner to offset 0.
// ----------------------------------------------------------------------------
module source_tokenizer import stok_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   stok_bundle_type bundle;
   logic            take;

   assign take = req_valid && req_ready;

   // scanner
   stok_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_word (req_data),
      .bundle  (bundle)
   );

   // token queue
   stok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .bundle    (bundle),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_data)
   );

endmodule

// ----- rtl/stok_checker.sv -----
// ----------------------------------------------------------------------------
// stok_checker: port-level checks of the source tokenizer
// Watches the top-level ports for token format and result channel behavior.
// ----------------------------------------------------------------------------
module stok_checker import stok_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   // a stalled token holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("token changed while stalled");

   // nothing left in the queue after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token shown right after reset");

   // eof closes the word's token group and is empty
   a_eof_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind == K_EOF) |->
         rsp_data.last && (rsp_data.token_length == '0))
      else $error("malformed eof token");

   // every real token covers at least one byte
   a_tok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind != K_EOF) |-> (rsp_data.token_length != '0))
      else $error("empty token");

   // comment error only on eof, string error only on strings
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_data.error_code == ERR_NONE) ||
          ((rsp_data.error_code == ERR_STRING) && (rsp_data.token_kind == K_STRING)) ||
          ((rsp_data.error_code == ERR_COMMENT) && (rsp_data.token_kind == K_EOF))))
      else $error("error code on wrong token kind");

endmodule

bind source_tokenizer stok_checker u_stok_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
